FILE: design/rbm_pkg.sv
// Shared types, register map codes and constants for the ROM bank mapper.
`default_nettype none

package rbm_pkg;

    // Kind of transaction carried on the input channel.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Address pages (address bits 15:12) that hold registers.
    localparam logic [3:0] PAGE_PRG0      = 4'h8;
    localparam logic [3:0] PAGE_MIRROR    = 4'h9;
    localparam logic [3:0] PAGE_PRG1      = 4'hA;
    localparam logic [3:0] PAGE_CHR_FIRST = 4'hB;
    localparam logic [3:0] PAGE_CHR_LAST  = 4'hE;
    localparam logic [3:0] PAGE_IRQ       = 4'hF;

    // Sub-register selected by the low address bits.
    typedef enum logic [1:0] {
        SUB_LOW  = 2'd0,
        SUB_HIGH = 2'd1,
        SUB_CTRL = 2'd2,
        SUB_ACK  = 2'd3
    } rbm_sub_t;

    // IRQ control bit positions.
    localparam int CTRL_ENABLE_AFTER_ACK = 0;
    localparam int CTRL_ENABLE           = 1;
    localparam int CTRL_CYCLE_MODE       = 2;

    localparam logic [7:0] COUNT_WRAP = 8'hFF;

    // Scanline lengths for each prescaler phase.
    localparam logic [6:0] SCANLINE_LONG  = 7'd114;
    localparam logic [6:0] SCANLINE_SHORT = 7'd113;
    localparam logic [1:0] PHASE_LAST     = 2'd2;

    // Decoded command for one transaction, already qualified by its advance.
    typedef struct packed {
        logic       tick;
        logic       prg0_we;
        logic       mirror_we;
        logic       prg1_we;
        logic       reload_lo_we;
        logic       reload_hi_we;
        logic       ctrl_we;
        logic       ack_we;
        logic       chr_we;
        logic [2:0] chr_sel;
        logic       chr_hi;
        logic [3:0] nibble;
        logic [2:0] ctrl_bits;
    } rbm_cmd_t;

    // Prescaler limit for a phase; the unreachable fourth phase uses the short line.
    function automatic logic [6:0] phase_limit(input logic [1:0] phase);
        logic [6:0] lim;
        unique case (phase)
            2'd0, 2'd1: lim = SCANLINE_LONG;
            default:    lim = SCANLINE_SHORT;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

FILE: design/rbm_decode.sv
// Register write decoder: turns one transaction into update strobes.
`default_nettype none

module rbm_decode (
    input  wire logic            fire,
    input  wire logic            action,
    input  wire logic [15:0]     address,
    input  wire logic [7:0]      write_data,
    output rbm_pkg::rbm_cmd_t    cmd
);
    import rbm_pkg::*;

    logic       sub_hit;
    rbm_sub_t   sub;
    logic [3:0] page;
    logic       wr;
    logic [3:0] chr_page;

    assign page     = address[15:12];
    assign chr_page = page - PAGE_CHR_FIRST;

    // Map the low twelve address bits onto a sub-register.
    always_comb
    begin
        sub_hit = 1'b1;
        unique case (address[11:0])
            12'h000:          sub = SUB_LOW;
            12'h001, 12'h004: sub = SUB_HIGH;
            12'h002, 12'h008: sub = SUB_CTRL;
            12'h003, 12'h00C: sub = SUB_ACK;
            default:
            begin
                sub     = SUB_LOW;
                sub_hit = 1'b0;
            end
        endcase
    end

    assign wr = fire && (action == ACT_WRITE) && sub_hit && address[15];

    // Page decode into per-register strobes.
    always_comb
    begin
        cmd              = '0;
        cmd.tick         = fire && (action == ACT_TICK);
        cmd.nibble       = write_data[3:0];
        cmd.ctrl_bits    = write_data[2:0];
        cmd.chr_sel      = {chr_page[1:0], sub[1]};
        cmd.chr_hi       = sub[0];
        unique case (page)
            PAGE_PRG0:   cmd.prg0_we   = wr;
            PAGE_MIRROR: cmd.mirror_we = wr;
            PAGE_PRG1:   cmd.prg1_we   = wr;
            PAGE_IRQ:
            begin
                cmd.reload_lo_we = wr && (sub == SUB_LOW);
                cmd.reload_hi_we = wr && (sub == SUB_HIGH);
                cmd.ctrl_we      = wr && (sub == SUB_CTRL);
                cmd.ack_we       = wr && (sub == SUB_ACK);
            end
            default:     cmd.chr_we = wr && (page >= PAGE_CHR_FIRST) &&
                                      (page <= PAGE_CHR_LAST);
        endcase
    end

endmodule

`default_nettype wire

FILE: design/rbm_irq.sv
// IRQ reload register, up-counter, scanline prescaler and IRQ line.
`default_nettype none

module rbm_irq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rbm_pkg::rbm_cmd_t cmd,
    output logic                  irq_request
);
    import rbm_pkg::*;

    logic [2:0] ctrl_reg,     ctrl_next;
    logic [7:0] reload_reg,   reload_next;
    logic [7:0] count_reg,    count_next;
    logic [6:0] prescale_reg, prescale_next;
    logic [1:0] phase_reg,    phase_next;
    logic       asserted_reg, asserted_next;
    logic [6:0] prescale_inc;
    logic       line_done;
    logic       clock_count;

    assign prescale_inc = prescale_reg + 7'd1;
    assign line_done    = prescale_inc >= phase_limit(phase_reg);

    // Counter clock: every enabled tick in cycle mode, at scanline end otherwise.
    assign clock_count = cmd.tick && ctrl_reg[CTRL_ENABLE] &&
                         (ctrl_reg[CTRL_CYCLE_MODE] || line_done);

    always_comb
    begin
        ctrl_next     = ctrl_reg;
        reload_next   = reload_reg;
        count_next    = count_reg;
        prescale_next = prescale_reg;
        phase_next    = phase_reg;
        asserted_next = asserted_reg;

        // Prescaler advances only on enabled ticks in scanline mode.
        if (cmd.tick && ctrl_reg[CTRL_ENABLE] && !ctrl_reg[CTRL_CYCLE_MODE])
        begin
            if (line_done)
            begin
                prescale_next = '0;
                phase_next    = (phase_reg >= PHASE_LAST) ? 2'd0 : phase_reg + 2'd1;
            end
            else
            begin
                prescale_next = prescale_inc;
            end
        end

        if (clock_count)
        begin
            if (count_reg == COUNT_WRAP)
            begin
                count_next    = reload_reg;
                asserted_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 8'd1;
            end
        end

        if (cmd.reload_lo_we)
        begin
            reload_next = {reload_reg[7:4], cmd.nibble};
        end
        if (cmd.reload_hi_we)
        begin
            reload_next = {cmd.nibble, reload_reg[3:0]};
        end

        // Control write releases the line and restarts an enabled counter.
        if (cmd.ctrl_we)
        begin
            ctrl_next     = cmd.ctrl_bits;
            asserted_next = 1'b0;
            if (cmd.ctrl_bits[CTRL_ENABLE])
            begin
                count_next    = reload_reg;
                prescale_next = '0;
                phase_next    = '0;
            end
        end

        // Acknowledge releases the line and sets enable from enable-after-ack.
        if (cmd.ack_we)
        begin
            asserted_next              = 1'b0;
            ctrl_next[CTRL_ENABLE]     = ctrl_reg[CTRL_ENABLE_AFTER_ACK];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg     <= '0;
            reload_reg   <= '0;
            count_reg    <= '0;
            prescale_reg <= '0;
            phase_reg    <= '0;
            asserted_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg     <= ctrl_next;
            reload_reg   <= reload_next;
            count_reg    <= count_next;
            prescale_reg <= prescale_next;
            phase_reg    <= phase_next;
            asserted_reg <= asserted_next;
        end
    end

    assign irq_request = asserted_reg;

endmodule

`default_nettype wire

FILE: design/rom_bank_mapper_with_irq_counter.sv
// Top level of the ROM bank mapper with IRQ counter.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+-------------------------------------------
//   input   | in_valid/in_ready  | action, address, write_data
//   output  | out_valid/out_ready| irq_request, prg_bank_*, mirror_mode,
//           |                    | chr_bank_0..chr_bank_7
//
// Each transaction is captured in an input register and applied to the mapper
// state once the result slot is free; the updated state is the result, and one
// transaction is accepted per cycle when the output is taken.
// While the output waits, one more transaction is held in the input register.
// Reset clears all bank, mirroring and IRQ state to zero.
`default_nettype none

module rom_bank_mapper_with_irq_counter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             irq_request,
    output logic [3:0]       prg_bank_first,
    output logic [3:0]       prg_bank_second,
    output logic [1:0]       mirror_mode,
    output logic [7:0]       chr_bank_0,
    output logic [7:0]       chr_bank_1,
    output logic [7:0]       chr_bank_2,
    output logic [7:0]       chr_bank_3,
    output logic [7:0]       chr_bank_4,
    output logic [7:0]       chr_bank_5,
    output logic [7:0]       chr_bank_6,
    output logic [7:0]       chr_bank_7
);
    import rbm_pkg::*;

    logic        s1_valid_reg,  s1_valid_next;
    logic        action_reg;
    logic [15:0] address_reg;
    logic [7:0]  data_reg;
    logic        out_valid_reg, out_valid_next;
    logic        in_fire;
    logic        advance;
    rbm_cmd_t    cmd;

    logic [3:0]  prg0_reg,   prg0_next;
    logic [3:0]  prg1_reg,   prg1_next;
    logic [1:0]  mirror_reg, mirror_next;
    logic [7:0]  chr_reg  [8];
    logic [7:0]  chr_next [8];

    // Handshake: the input stage moves on whenever the result slot is free.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg  <= action;
            address_reg <= address;
            data_reg    <= write_data;
        end
    end

    rbm_decode u_decode (
        .fire       (advance),
        .action     (action_reg),
        .address    (address_reg),
        .write_data (data_reg),
        .cmd        (cmd)
    );

    rbm_irq u_irq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .irq_request (irq_request)
    );

    // Bank and mirroring register updates.
    always_comb
    begin
        prg0_next   = cmd.prg0_we   ? cmd.nibble : prg0_reg;
        prg1_next   = cmd.prg1_we   ? cmd.nibble : prg1_reg;
        mirror_next = cmd.mirror_we ? cmd.nibble[1:0] : mirror_reg;
        for (int i = 0; i < 8; i++)
        begin
            chr_next[i] = chr_reg[i];
            if (cmd.chr_we && (cmd.chr_sel == 3'(i)))
            begin
                chr_next[i] = cmd.chr_hi ? {cmd.nibble, chr_reg[i][3:0]}
                                         : {chr_reg[i][7:4], cmd.nibble};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg0_reg   <= '0;
            prg1_reg   <= '0;
            mirror_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chr_reg[i] <= '0;
            end
        end
        else
        begin
            prg0_reg   <= prg0_next;
            prg1_reg   <= prg1_next;
            mirror_reg <= mirror_next;
            for (int i = 0; i < 8; i++)
            begin
                chr_reg[i] <= chr_next[i];
            end
        end
    end

    // The state registers change only when a result is loaded, so they are the result.
    assign out_valid       = out_valid_reg;
    assign prg_bank_first  = prg0_reg;
    assign prg_bank_second = prg1_reg;
    assign mirror_mode     = mirror_reg;
    assign chr_bank_0      = chr_reg[0];
    assign chr_bank_1      = chr_reg[1];
    assign chr_bank_2      = chr_reg[2];
    assign chr_bank_3      = chr_reg[3];
    assign chr_bank_4      = chr_reg[4];
    assign chr_bank_5      = chr_reg[5];
    assign chr_bank_6      = chr_reg[6];
    assign chr_bank_7      = chr_reg[7];

endmodule

`default_nettype wire

FILE: tb/mapper_bank_checker.sv
// Register offsets shared by the mapper testbench, and the checker that predicts and compares results.
`timescale 1ns / 1ps

package mapper_tb_pkg;

    // Low address bits that select a sub-register within a register page.
    localparam logic [11:0] OFS_LOW      = 12'h000;
    localparam logic [11:0] OFS_HIGH     = 12'h001;
    localparam logic [11:0] OFS_CTRL     = 12'h002;
    localparam logic [11:0] OFS_ACK      = 12'h003;
    localparam logic [11:0] OFS_HIGH_ALT = 12'h004;
    localparam logic [11:0] OFS_CTRL_ALT = 12'h008;
    localparam logic [11:0] OFS_ACK_ALT  = 12'h00C;

endpackage

module mapper_bank_checker
    import rbm_pkg::*;
    import mapper_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        irq_request,
    input  logic [3:0]  prg_bank_first,
    input  logic [3:0]  prg_bank_second,
    input  logic [1:0]  mirror_mode,
    input  logic [7:0]  chr_bank_0,
    input  logic [7:0]  chr_bank_1,
    input  logic [7:0]  chr_bank_2,
    input  logic [7:0]  chr_bank_3,
    input  logic [7:0]  chr_bank_4,
    input  logic [7:0]  chr_bank_5,
    input  logic [7:0]  chr_bank_6,
    input  logic [7:0]  chr_bank_7,
    output int          mismatches,
    output int          outstanding
);

    // Everything the mapper shows on its result channel.
    typedef struct packed {
        logic            irq;
        logic [3:0]      prg_first;
        logic [3:0]      prg_second;
        logic [1:0]      mirror;
        logic [7:0][7:0] chr;
    } mapper_view_t;

    // Mapper views predicted for accepted transactions, oldest first.
    mapper_view_t predicted_views[$];

    // Predicted mapper state.
    logic [2:0] irq_ctrl;
    logic [7:0] irq_reload;
    logic [7:0] irq_counter;
    logic [6:0] prescale;
    logic [1:0] phase;
    logic       irq_line;
    logic [3:0] prg_bank[2];
    logic [1:0] mirror_sel;
    logic [7:0] chr_bank[8];

    task automatic clear_state();
        irq_ctrl    = '0;
        irq_reload  = '0;
        irq_counter = '0;
        prescale    = '0;
        phase       = '0;
        irq_line    = 1'b0;
        prg_bank[0] = '0;
        prg_bank[1] = '0;
        mirror_sel  = '0;
        for (int i = 0; i < 8; i++)
        begin
            chr_bank[i] = '0;
        end
    endtask

    // One step of the IRQ up-counter; it reloads and raises the line on wrap.
    task automatic advance_counter();
        if (irq_counter == COUNT_WRAP)
        begin
            irq_counter = irq_reload;
            irq_line    = 1'b1;
        end
        else
        begin
            irq_counter = irq_counter + 8'd1;
        end
    endtask

    // A CPU cycle either clocks the counter directly or feeds the scanline prescaler.
    task automatic count_cpu_cycle();
        logic [6:0] line_len;
        line_len = (phase >= PHASE_LAST) ? SCANLINE_SHORT : SCANLINE_LONG;
        if (!irq_ctrl[CTRL_ENABLE])
            return;
        if (irq_ctrl[CTRL_CYCLE_MODE])
        begin
            advance_counter();
            return;
        end
        prescale = prescale + 7'd1;
        if (prescale >= line_len)
        begin
            prescale = '0;
            phase    = (phase >= PHASE_LAST) ? 2'd0 : phase + 2'd1;
            advance_counter();
        end
    endtask

    // Maps the low address bits to a sub-register; returns 0 for an unlisted offset.
    function automatic logic decode_sub(input logic [11:0] ofs, output rbm_sub_t sub);
        logic hit;
        hit = 1'b1;
        sub = SUB_LOW;
        case (ofs)
            OFS_LOW:                sub = SUB_LOW;
            OFS_HIGH, OFS_HIGH_ALT: sub = SUB_HIGH;
            OFS_CTRL, OFS_CTRL_ALT: sub = SUB_CTRL;
            OFS_ACK, OFS_ACK_ALT:   sub = SUB_ACK;
            default:                hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Register write decode; only the low bits of the data byte matter.
    task automatic write_register(input logic [15:0] addr, input logic [7:0] data);
        logic [3:0] page;
        logic [3:0] rel_page;
        logic [2:0] bank;
        logic       hit;
        rbm_sub_t   sub;
        page = addr[15:12];
        hit  = decode_sub(addr[11:0], sub);
        if (page < PAGE_PRG0 || !hit)
            return;
        case (page)
            PAGE_PRG0:   prg_bank[0] = data[3:0];
            PAGE_MIRROR: mirror_sel = data[1:0];
            PAGE_PRG1:   prg_bank[1] = data[3:0];
            PAGE_IRQ:
            begin
                case (sub)
                    SUB_LOW:  irq_reload[3:0] = data[3:0];
                    SUB_HIGH: irq_reload[7:4] = data[3:0];
                    SUB_CTRL:
                    begin
                        irq_ctrl = data[2:0];
                        irq_line = 1'b0;
                        if (irq_ctrl[CTRL_ENABLE])
                        begin
                            irq_counter = irq_reload;
                            prescale    = '0;
                            phase       = '0;
                        end
                    end
                    default:
                    begin
                        // Acknowledge leaves the counter and prescaler alone.
                        irq_line = 1'b0;
                        irq_ctrl[CTRL_ENABLE] = irq_ctrl[CTRL_ENABLE_AFTER_ACK];
                    end
                endcase
            end
            default:
            begin
                // Pattern pages hold two banks each, loaded a nibble at a time.
                rel_page = page - PAGE_CHR_FIRST;
                bank     = {rel_page[1:0], sub[1]};
                if (sub[0])
                    chr_bank[bank][7:4] = data[3:0];
                else
                    chr_bank[bank][3:0] = data[3:0];
            end
        endcase
    endtask

    function automatic mapper_view_t current_view();
        mapper_view_t v;
        v.irq        = irq_line;
        v.prg_first  = prg_bank[0];
        v.prg_second = prg_bank[1];
        v.mirror     = mirror_sel;
        for (int i = 0; i < 8; i++)
        begin
            v.chr[i] = chr_bank[i];
        end
        return v;
    endfunction

    task automatic compare_view(input mapper_view_t want, input mapper_view_t got);
        if (got.irq !== want.irq)
        begin
            $error("irq_request: expected %0d, actual %0d", want.irq, got.irq);
            mismatches = mismatches + 1;
        end
        if (got.prg_first !== want.prg_first)
        begin
            $error("prg_bank_first: expected %0d, actual %0d", want.prg_first, got.prg_first);
            mismatches = mismatches + 1;
        end
        if (got.prg_second !== want.prg_second)
        begin
            $error("prg_bank_second: expected %0d, actual %0d",
                   want.prg_second, got.prg_second);
            mismatches = mismatches + 1;
        end
        if (got.mirror !== want.mirror)
        begin
            $error("mirror_mode: expected %0d, actual %0d", want.mirror, got.mirror);
            mismatches = mismatches + 1;
        end
        for (int i = 0; i < 8; i++)
        begin
            if (got.chr[i] !== want.chr[i])
            begin
                $error("chr_bank_%0d: expected 0x%02h, actual 0x%02h", i, want.chr[i], got.chr[i]);
                mismatches = mismatches + 1;
            end
        end
    endtask

    // Predict on each input transaction, compare on each output transaction.
    always @(posedge clk or negedge rst_n)
    begin
        mapper_view_t got;
        if (!rst_n)
        begin
            clear_state();
            predicted_views.delete();
            outstanding = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (action == ACT_WRITE)
                    write_register(address, write_data);
                else
                    count_cpu_cycle();
                predicted_views.push_back(current_view());
            end
            if (out_valid && out_ready)
            begin
                got.irq        = irq_request;
                got.prg_first  = prg_bank_first;
                got.prg_second = prg_bank_second;
                got.mirror     = mirror_mode;
                got.chr        = {chr_bank_7, chr_bank_6, chr_bank_5, chr_bank_4,
                                  chr_bank_3, chr_bank_2, chr_bank_1, chr_bank_0};
                if (predicted_views.size() == 0)
                begin
                    $error("result transaction arrived with no prediction pending");
                    mismatches = mismatches + 1;
                end
                else
                begin
                    compare_view(predicted_views.pop_front(), got);
                end
            end
            outstanding = predicted_views.size();
        end
    end

endmodule

FILE: tb/rom_bank_mapper_with_irq_counter_tb.sv
// Top of the mapper testbench: clock, reset, stimulus, output pacing and the verdict.
`timescale 1ns / 1ps

module rom_bank_mapper_with_irq_counter_tb;

    import rbm_pkg::*;
    import mapper_tb_pkg::*;

    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 150;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_ready;
    logic        irq_request;
    logic [3:0]  prg_bank_first;
    logic [3:0]  prg_bank_second;
    logic [1:0]  mirror_mode;
    logic [7:0]  chr_bank_0;
    logic [7:0]  chr_bank_1;
    logic [7:0]  chr_bank_2;
    logic [7:0]  chr_bank_3;
    logic [7:0]  chr_bank_4;
    logic [7:0]  chr_bank_5;
    logic [7:0]  chr_bank_6;
    logic [7:0]  chr_bank_7;

    int mismatches;
    int outstanding;
    int items_sent;
    int cycle_count;

    rom_bank_mapper_with_irq_counter u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .address         (address),
        .write_data      (write_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .irq_request     (irq_request),
        .prg_bank_first  (prg_bank_first),
        .prg_bank_second (prg_bank_second),
        .mirror_mode     (mirror_mode),
        .chr_bank_0      (chr_bank_0),
        .chr_bank_1      (chr_bank_1),
        .chr_bank_2      (chr_bank_2),
        .chr_bank_3      (chr_bank_3),
        .chr_bank_4      (chr_bank_4),
        .chr_bank_5      (chr_bank_5),
        .chr_bank_6      (chr_bank_6),
        .chr_bank_7      (chr_bank_7)
    );

    mapper_bank_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .address         (address),
        .write_data      (write_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .irq_request     (irq_request),
        .prg_bank_first  (prg_bank_first),
        .prg_bank_second (prg_bank_second),
        .mirror_mode     (mirror_mode),
        .chr_bank_0      (chr_bank_0),
        .chr_bank_1      (chr_bank_1),
        .chr_bank_2      (chr_bank_2),
        .chr_bank_3      (chr_bank_3),
        .chr_bank_4      (chr_bank_4),
        .chr_bank_5      (chr_bank_5),
        .chr_bank_6      (chr_bank_6),
        .chr_bank_7      (chr_bank_7),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    // 250 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int random_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [11:0] pick_offset();
        case ($urandom_range(0, 6))
            0:       return OFS_LOW;
            1:       return OFS_HIGH;
            2:       return OFS_CTRL;
            3:       return OFS_ACK;
            4:       return OFS_HIGH_ALT;
            5:       return OFS_CTRL_ALT;
            default: return OFS_ACK_ALT;
        endcase
    endfunction

    // Offer one transaction and hold it until the mapper takes it.
    task automatic send_item(input logic act, input logic [15:0] addr, input logic [7:0] data);
        int gap;
        gap = ((items_sent / 200) % 3 == 2) ? 0 : random_pause();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        address    <= addr;
        write_data <= data;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent = items_sent + 1;
    endtask

    task automatic write_reg(input logic [3:0] page, input logic [11:0] ofs,
                             input logic [7:0] data);
        send_item(ACT_WRITE, {page, ofs}, data);
    endtask

    // Ticks carry random address and data, which the mapper must ignore.
    task automatic cpu_tick();
        send_item(ACT_TICK, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)));
    endtask

    // Bank or mirroring write that leaves the IRQ registers alone.
    task automatic bank_write();
        write_reg(4'($urandom_range(PAGE_PRG0, PAGE_CHR_LAST)), pick_offset(),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic run_directed();
        // Bank registers at data extremes, covering each pattern page.
        write_reg(PAGE_PRG0, OFS_LOW, 8'hFF);
        write_reg(PAGE_MIRROR, OFS_HIGH_ALT, 8'hFE);
        write_reg(PAGE_PRG1, OFS_ACK_ALT, 8'h0A);
        write_reg(PAGE_CHR_FIRST, OFS_LOW, 8'hFF);
        write_reg(PAGE_CHR_FIRST, OFS_HIGH_ALT, 8'h3C);
        write_reg(4'hC, OFS_ACK_ALT, 8'hF5);
        write_reg(4'hD, OFS_CTRL, 8'h07);
        write_reg(PAGE_CHR_LAST, OFS_HIGH, 8'h81);
        write_reg(PAGE_CHR_LAST, OFS_ACK, 8'hFF);
        // Unlisted offset, address below the register space, top address.
        send_item(ACT_WRITE, 16'hB005, 8'hFF);
        send_item(ACT_WRITE, 16'h7000, 8'hFF);
        send_item(ACT_WRITE, 16'hFFFF, 8'hFF);
        // Reload near the wrap point, then count in cycle mode until the IRQ fires.
        write_reg(PAGE_IRQ, OFS_LOW, 8'hFE);
        write_reg(PAGE_IRQ, OFS_HIGH_ALT, 8'h0F);
        write_reg(PAGE_IRQ, OFS_CTRL, 8'hFE);
        cpu_tick();
        cpu_tick();
        cpu_tick();
        // Acknowledge with enable-after-ack clear disables counting.
        write_reg(PAGE_IRQ, OFS_ACK_ALT, 8'h00);
        cpu_tick();
        // Control with only enable-after-ack, then an acknowledge turns on scanline mode.
        write_reg(PAGE_IRQ, OFS_CTRL_ALT, 8'hF9);
        write_reg(PAGE_IRQ, OFS_ACK, 8'h00);
        cpu_tick();
        write_reg(PAGE_PRG0, OFS_CTRL_ALT, 8'h00);
        write_reg(PAGE_MIRROR, OFS_LOW, 8'h03);
    endtask

    // Well-formed IRQ setup followed by a run of ticks and usually an acknowledge.
    task automatic irq_episode();
        logic       scanline;
        logic [2:0] ctrl;
        logic [3:0] reload_hi;
        int         n;
        scanline  = ($urandom_range(0, 9) < 3);
        reload_hi = ($urandom_range(0, 4) != 0) ? 4'hF : 4'($urandom_range(0, 15));
        write_reg(PAGE_IRQ, OFS_LOW, 8'($urandom_range(0, 255)));
        write_reg(PAGE_IRQ, $urandom_range(0, 1) ? OFS_HIGH : OFS_HIGH_ALT,
                  {4'($urandom_range(0, 15)), reload_hi});
        ctrl = 3'($urandom_range(0, 7));
        ctrl[CTRL_ENABLE]     = ($urandom_range(0, 9) != 0);
        ctrl[CTRL_CYCLE_MODE] = !scanline;
        write_reg(PAGE_IRQ, $urandom_range(0, 1) ? OFS_CTRL : OFS_CTRL_ALT,
                  {5'($urandom_range(0, 31)), ctrl});
        n = scanline ? $urandom_range(60, 250) : $urandom_range(1, 40);
        repeat (n)
        begin
            if ($urandom_range(0, 19) == 0)
                bank_write();
            else
                cpu_tick();
        end
        if ($urandom_range(0, 9) < 7)
            write_reg(PAGE_IRQ, $urandom_range(0, 1) ? OFS_ACK : OFS_ACK_ALT,
                      8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 5)) cpu_tick();
    endtask

    // Random register traffic with noise addresses and a few ticks.
    task automatic write_burst();
        repeat ($urandom_range(5, 20))
        begin
            case ($urandom_range(0, 9))
                0, 1:    cpu_tick();
                2:       send_item(ACT_WRITE, 16'($urandom_range(0, 16'hFFFF)),
                                   8'($urandom_range(0, 255)));
                default: write_reg(4'($urandom_range(PAGE_PRG0, PAGE_IRQ)), pick_offset(),
                                   8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Reset, stimulus, drain and verdict.
    initial
    begin
        rst_n      = 1'b0;
        in_valid   <= 1'b0;
        action     <= ACT_TICK;
        address    <= '0;
        write_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 6)
                irq_episode();
            else
                write_burst();
        end
        in_valid <= 1'b0;
        // Let the checker record the last accepted transaction before polling its count.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Output pacing, with one long hold-off so the mapper backs up into its input.
    initial
    begin
        int stall;
        bit long_hold_done;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && items_sent >= 300)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                stall = ((cycle_count / 500) % 4 == 3) ? 0 : random_pause();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

endmodule
